// ===== hdl/rotlock_pkg.sv =====
// ----------------------------------------------------------------------------
// rotlock_pkg
// types and constants shared by the rotary encoder combination lock
// ----------------------------------------------------------------------------
package rotlock_pkg;

  localparam int NUM_CODES = 6;
  localparam int CODE_W    = 8;
  localparam int STAGE_W   = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [CODE_W-1:0] code_t;
  typedef code_t [NUM_CODES-1:0]    code_array_t;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FOURTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FIFTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SIXTH  = 3'd5;

  // reset combination
  localparam code_t CODE_FIRST_RST  = 8'sd8;
  localparam code_t CODE_SECOND_RST = -8'sd2;
  localparam code_t CODE_THIRD_RST  = 8'sd8;
  localparam code_t CODE_FOURTH_RST = 8'sd7;
  localparam code_t CODE_FIFTH_RST  = 8'sd17;
  localparam code_t CODE_SIXTH_RST  = 8'sd0;

  localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(NUM_CODES);

  typedef struct packed {
    logic pin_a;
    logic pin_b;
  } in_word_t;

  typedef struct packed {
    code_t              position;
    logic               moved;
    logic               clockwise;
    logic [STAGE_W-1:0] stage;
    logic               unlock;
  } out_word_t;

endpackage

// ===== hdl/rotlock_cfg.sv =====
// ----------------------------------------------------------------------------
// rotlock_cfg
// combination code registers written through the configuration port
// ----------------------------------------------------------------------------
module rotlock_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [rotlock_pkg::CFG_IDX_W-1:0]   wr_index,
  input  rotlock_pkg::code_t                  wr_data,
  output rotlock_pkg::code_array_t            codes
);
  import rotlock_pkg::*;

  code_array_t codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r[0] <= CODE_FIRST_RST;
      codes_r[1] <= CODE_SECOND_RST;
      codes_r[2] <= CODE_THIRD_RST;
      codes_r[3] <= CODE_FOURTH_RST;
      codes_r[4] <= CODE_FIFTH_RST;
      codes_r[5] <= CODE_SIXTH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CODE_FIRST:  codes_r[0] <= wr_data;
        REG_CODE_SECOND: codes_r[1] <= wr_data;
        REG_CODE_THIRD:  codes_r[2] <= wr_data;
        REG_CODE_FOURTH: codes_r[3] <= wr_data;
        REG_CODE_FIFTH:  codes_r[4] <= wr_data;
        REG_CODE_SIXTH:  codes_r[5] <= wr_data;
        default: ;
      endcase
    end
  end

  assign codes = codes_r;

endmodule

// ===== hdl/rotlock_core.sv =====
// ----------------------------------------------------------------------------
// rotlock_core
// quadrature decode and combination stage tracking for one word per step
// ----------------------------------------------------------------------------
module rotlock_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  rotlock_pkg::in_word_t     word,
  input  rotlock_pkg::code_array_t  codes,
  output rotlock_pkg::out_word_t    result
);
  import rotlock_pkg::*;

  logic               prev_a_r, prev_a_nxt;
  code_t              count_r, count_nxt;
  logic               dir_r, dir_nxt;
  logic [STAGE_W-1:0] stage_r, stage_nxt;
  logic               moved;
  logic               unlock;
  logic [STAGE_W-1:0] stage_v;

  always_comb begin
    moved      = word.pin_a != prev_a_r;
    prev_a_nxt = word.pin_a;
    count_nxt  = count_r;
    dir_nxt    = dir_r;
    if (moved) begin
      if (word.pin_b == word.pin_a) begin
        count_nxt = count_r + 8'sd1;
        dir_nxt   = 1'b1;
      end else begin
        count_nxt = count_r - 8'sd1;
        dir_nxt   = 1'b0;
      end
    end
    // stages cascade in order
    stage_v = stage_r;
    for (int s = 0; s < NUM_CODES; s++) begin
      if (stage_v == STAGE_W'(s) && count_nxt == codes[s]) begin
        stage_v = STAGE_W'(s + 1);
      end
    end
    unlock    = stage_v == STAGE_LAST;
    stage_nxt = unlock ? '0 : stage_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0;
      count_r  <= '0;
      dir_r    <= 1'b0;
      stage_r  <= '0;
    end else if (step) begin
      prev_a_r <= prev_a_nxt;
      count_r  <= count_nxt;
      dir_r    <= dir_nxt;
      stage_r  <= stage_nxt;
    end
  end

  assign result.position  = count_nxt;
  assign result.moved     = moved;
  assign result.clockwise = dir_nxt;
  assign result.stage     = stage_nxt;
  assign result.unlock    = unlock;

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r < STAGE_LAST)
    else $error("stage out of range");

  a_hold_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    step && !moved |=> $stable(count_r) && $stable(dir_r))
    else $error("count changed without movement");

endmodule

// ===== hdl/rotary_encoder_combination_lock_top.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_combination_lock_top
// quadrature encoder decoder with a six word combination lock
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_word (pin_a, pin_b)
//   out_     output     out_valid/out_stall  out_word (position .. unlock)
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low; a word goes from
// in_ to out_ through the input register, then through the decode and
// stage logic into the output register. the input register takes a word
// while a result still waits on out_. reset is synchronous and restores
// the reset code words; cfg_ready is always high
// ----------------------------------------------------------------------------
module rotary_encoder_combination_lock_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rotlock_pkg::in_word_t             in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rotlock_pkg::out_word_t            out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rotlock_pkg::CFG_IDX_W-1:0] cfg_index,
  input  rotlock_pkg::code_t                cfg_data
);
  import rotlock_pkg::*;

  logic        in_vld_r;
  in_word_t    in_word_r;
  logic        out_vld_r;
  out_word_t   out_word_r;
  logic        adv;
  code_array_t codes;
  out_word_t   result;

  // stage 1 moves into the output register when it is free or being taken
  assign adv       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= result;
    end
  end

  rotlock_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .codes    (codes)
  );

  rotlock_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .word   (in_word_r),
    .codes  (codes),
    .result (result)
  );

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  a_unlock_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_word_r.unlock |-> out_word_r.stage == '0)
    else $error("unlock with nonzero stage");

  a_out_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_word_r.stage < STAGE_LAST)
    else $error("output stage out of range");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_word_r))
    else $error("held input word lost");

endmodule
